// ----- hw/rtl/sli_pkg.sv -----
// shared types, constants and status codes for the sorted list core
package sli_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 8;

  typedef logic [1:0] status_t;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic    load;          // capture input word, index to zero
    logic    idx_top;       // index to last held entry
    logic    idx_dec;
    logic    idx_inc;
    logic    rd;            // read entry at index
    logic    wr_shift_up;   // entry[idx+1] = read data
    logic    wr_val_above;  // entry[idx+1] = value
    logic    wr_val_at;     // entry[idx]   = value
    logic    wr_shift_down; // entry[idx-1] = read data
    logic    set_found;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func;
    logic full;
    logic empty;
    logic ge;        // read data >= value, signed
    logic eq;        // read data == value
    logic idx_zero;
    logic idx_last;
    logic found;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/sli_if.sv -----
// handshake channels for input and result words
interface sli_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface sli_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         count;
  logic               head_valid;
  logic signed [31:0] head_value;

  modport source (output valid, status, count, head_valid, head_value, input ready);
  modport sink   (input valid, status, count, head_valid, head_value, output ready);
endinterface

// ----- hw/rtl/sorted_list_insert_remove_core.sv -----
// Sorted list of up to DEPTH signed 32-bit values held in one single-port-write,
// registered-read memory. An insert walks down from the top entry, moving each
// entry that is larger or equal up one slot, and drops the value into the gap;
// a remove walks up from entry zero, and once it meets the first equal value
// moves every later entry down one. Each visited entry takes an address step, then
// a compare and write step. An insert into a full or empty list and a remove from
// an empty list skip the walk.
// One word is worked on at a time; a new word is taken as
// soon as the previous result sits in the output register, even if not yet taken.
// Every word gives one result with status, count after the operation and the
// smallest held value (zero when empty). No clearing pass follows reset.
module sorted_list_insert_remove_core
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  sli_in_if.sink    in_ch,
  sli_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t st;

  sli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sli_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_func  (in_ch.func),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .st       (st),
    .out_ch   (out_ch)
  );

endmodule

// ----- hw/rtl/sli_ctrl.sv -----
// sequencing state machine for insert and remove walks
module sli_ctrl
  import sli_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (st.func == FUNC_INSERT) begin
          if (st.full) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_FULL;
            state_nxt      = S_DONE;
          end else if (st.empty) begin
            cmd.wr_val_at  = 1'b1;
            cmd.cnt_inc    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_DONE;
            state_nxt      = S_DONE;
          end else begin
            cmd.idx_top = 1'b1;
            state_nxt   = S_RD;
          end
        end else begin
          if (st.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (st.func == FUNC_INSERT) begin
          // walk down from the top, moving larger or equal entries up one
          if (st.ge) begin
            cmd.wr_shift_up = 1'b1;
            if (st.idx_zero) begin
              state_nxt = S_PUT;
            end else begin
              cmd.idx_dec = 1'b1;
              state_nxt   = S_RD;
            end
          end else begin
            cmd.wr_val_above = 1'b1;
            cmd.cnt_inc      = 1'b1;
            cmd.set_status   = 1'b1;
            cmd.status       = ST_DONE;
            state_nxt        = S_DONE;
          end
        end else begin
          // walk up from the bottom, closing the gap once the match is seen
          if (st.found) begin
            cmd.wr_shift_down = 1'b1;
          end else if (st.eq) begin
            cmd.set_found = 1'b1;
          end
          if (st.idx_last) begin
            cmd.set_status = 1'b1;
            if (st.found || st.eq) begin
              cmd.cnt_dec = 1'b1;
              cmd.status  = ST_DONE;
            end else begin
              cmd.status = ST_NOT_FOUND;
            end
            state_nxt = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_PUT: begin
        cmd.wr_val_at  = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_DONE;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sli_dpath.sv -----
// entry memory, index, count, head and result register
module sli_dpath
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_func,
  input  logic [31:0]  in_value,
  input  cmd_t         cmd,
  output stat_t        st,
  sli_out_if.source    out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [VAL_W-1:0]        mem [DEPTH];
  logic [VAL_W-1:0]        rd_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    func_r;
  logic [AW-1:0]           idx_r;
  logic [CW-1:0]           count_r;
  logic                    found_r;
  logic [VAL_W-1:0]        head_r;
  status_t                 status_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic                    out_hv_r;
  logic [VAL_W-1:0]        out_hval_r;

  logic                    we;
  logic [AW-1:0]           wa;
  logic [VAL_W-1:0]        wd;

  always_comb begin
    we = cmd.wr_shift_up | cmd.wr_val_above | cmd.wr_val_at | cmd.wr_shift_down;
    wa = idx_r;
    wd = value_r;
    if (cmd.wr_shift_up) begin
      wa = idx_r + AW'(1);
      wd = rd_r;
    end else if (cmd.wr_val_above) begin
      wa = idx_r + AW'(1);
    end else if (cmd.wr_shift_down) begin
      wa = idx_r - AW'(1);
      wd = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rd_r <= mem[idx_r];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      func_r  <= in_func;
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.idx_top) begin
      idx_r <= AW'(count_r - CW'(1));
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - AW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    // entry zero is mirrored here so the head needs no memory read
    if (we && (wa == '0)) begin
      head_r <= wd;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_count_r  <= CNT_OUT_W'(count_r);
      out_hv_r     <= (count_r != '0);
      out_hval_r   <= (count_r != '0) ? head_r : '0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmd.set_found) begin
        found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.func     = func_r;
    st.full     = (count_r == CW'(DEPTH));
    st.empty    = (count_r == '0);
    st.ge       = ($signed(rd_r) >= value_r);
    st.eq       = (rd_r == value_r);
    st.idx_zero = (idx_r == '0);
    st.idx_last = ((CW'(idx_r) + CW'(1)) == count_r);
    st.found    = found_r;
    st.out_free = !out_valid_r || out_ch.ready;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.head_valid = out_hv_r;
  assign out_ch.head_value = out_hval_r;

endmodule

// ----- hw/rtl/sli_checker.sv -----
// port-level checks on result words, bound to the core
module sli_checker
  import sli_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_count,
  input logic        out_head_valid,
  input logic [31:0] out_head_value
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("result word dropped or changed while stalled");

  // with no count wrap the head flag follows the count
  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DEPTH < 256) |-> (out_head_valid == (out_count != 8'd0)))
    else $error("head flag disagrees with count");

  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_head_value == 32'd0)
    else $error("empty list shows a non-zero head");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_head_valid && (out_count == 8'(DEPTH)))
    else $error("full status with wrong count");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> !out_head_valid && (out_count == 8'd0))
    else $error("empty status on a non-empty list");

endmodule

bind sorted_list_insert_remove_core sli_checker #(
  .DEPTH (DEPTH)
) u_sli_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_count      (out_ch.count),
  .out_head_valid (out_ch.head_valid),
  .out_head_value (out_ch.head_value)
);
